/* rtl/core/reduce_scatter_halving_scheduler_macros.svh */
// Assertion macros shared by the reduce-scatter schedule generator modules.
// No dependencies; included by the modules that carry assertions.
`ifndef REDUCE_SCATTER_HALVING_SCHEDULER_MACROS_SVH
`define REDUCE_SCATTER_HALVING_SCHEDULER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define RSHS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define RSHS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rshs_pkg.sv */
// Shared types, codes and helpers of the recursive-halving reduce-scatter
// schedule generator. No dependencies.
`default_nettype none

package rshs_pkg;

    // Largest communicator handled; larger group sizes saturate to this
    localparam int MAX_RANKS = 64;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [0:0] REG_GROUP_SIZE = 1'b0;
    localparam logic [0:0] REG_MY_RANK    = 1'b1;

    // Schedule item kinds
    typedef enum logic [3:0] {
        KIND_EMPTY      = 4'd0,
        KIND_LOAD_SEND  = 4'd1,
        KIND_LOAD_RECV  = 4'd2,
        KIND_SEND_ALL   = 4'd3,
        KIND_RECV_ALL   = 4'd4,
        KIND_ROUND      = 4'd5,
        KIND_COPY_OUT   = 4'd6,
        KIND_SEND_RES   = 4'd7,
        KIND_RECV_RES   = 4'd8
    } kind_t;

    // Part this rank plays in the non-power-of-two fold
    typedef enum logic [1:0] {
        ROLE_PLAIN,
        ROLE_FOLD_SEND,
        ROLE_FOLD_RECV
    } role_t;

    // Back-end sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EMPTY,
        PH_LOAD,
        PH_FOLD_IN,
        PH_ROUND,
        PH_COPY,
        PH_FOLD_OUT
    } phase_t;

    // Classified start command
    typedef struct packed {
        logic        empty;
        logic        in_place;
        logic [19:0] blk;
        logic [26:0] total;
        logic [25:0] rank_blk;
        logic [5:0]  rank;
        logic [5:0]  rem;
        logic [6:0]  pof2;
        logic [6:0]  vrank;
        role_t       role;
    } desc_t;

    // Queue write side
    typedef struct packed {
        logic  push;
        desc_t data;
    } q_wr_t;

    // Queue read side status
    typedef struct packed {
        logic  valid;
        desc_t data;
    } q_rd_t;

    // One schedule item
    typedef struct packed {
        kind_t       kind;
        logic [5:0]  peer;
        logic [25:0] send_offset;
        logic [26:0] send_count;
        logic [25:0] recv_offset;
        logic [26:0] recv_count;
        logic        send_active;
        logic        recv_active;
        logic        last;
    } item_t;

    // Element offset of virtual block idx: blocks below rem are double size
    function automatic logic [26:0] vdisp(input logic [6:0] idx, input logic [5:0] rem,
                                          input logic [19:0] blk);
        logic [6:0]  lo;
        logic [7:0]  sum;
        logic [27:0] prod;
        lo   = (idx < {1'b0, rem}) ? idx : {1'b0, rem};
        sum  = {1'b0, idx} + {1'b0, lo};
        prod = 28'(sum) * 28'(blk);
        return prod[26:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rshs_front.sv */
// Front end: configuration registers, start command accept and classification.
// Depends on rshs_pkg.
`default_nettype none

module rshs_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // configuration write channel
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [0:0]     cfg_index,
    input  wire logic [6:0]     cfg_data,
    // start command
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [19:0]    blk_in,
    input  wire logic           in_place_in,
    // queue
    input  wire logic           q_full,
    output rshs_pkg::q_wr_t     q_wr
);

    logic [6:0] group_size_reg, group_size_next;
    logic [5:0] my_rank_reg, my_rank_next;

    logic [6:0]  size_sat;
    logic [6:0]  pof2;
    logic [5:0]  rem;
    rshs_pkg::desc_t desc;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    // Register writes
    always_comb begin
        group_size_next = group_size_reg;
        my_rank_next    = my_rank_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                rshs_pkg::REG_GROUP_SIZE: group_size_next = cfg_data;
                rshs_pkg::REG_MY_RANK:    my_rank_next    = cfg_data[5:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= 7'd1;
            my_rank_reg    <= 6'd0;
        end else begin
            group_size_reg <= group_size_next;
            my_rank_reg    <= my_rank_next;
        end
    end

    // Group size saturation and largest power of two not above it
    always_comb begin
        size_sat = (group_size_reg > 7'(rshs_pkg::MAX_RANKS)) ?
                   7'(rshs_pkg::MAX_RANKS) : group_size_reg;
        pof2 = 7'd1;
        for (int i = 0; i < 7; i++) begin
            if (size_sat[i]) begin
                pof2 = 7'(1 << i);
            end
        end
        rem = 6'(size_sat - pof2);
    end

    // Command classification
    always_comb begin
        desc.empty    = (blk_in == 20'd0) || ({1'b0, my_rank_reg} >= size_sat);
        desc.in_place = in_place_in;
        desc.blk      = blk_in;
        desc.total    = 27'(size_sat) * 27'(blk_in);
        desc.rank_blk = 26'(my_rank_reg) * 26'(blk_in);
        desc.rank     = my_rank_reg;
        desc.rem      = rem;
        desc.pof2     = pof2;
        if ({1'b0, my_rank_reg} < {rem, 1'b0}) begin
            desc.role  = my_rank_reg[0] ? rshs_pkg::ROLE_FOLD_RECV : rshs_pkg::ROLE_FOLD_SEND;
            desc.vrank = {2'b00, my_rank_reg[5:1]};
        end else begin
            desc.role  = rshs_pkg::ROLE_PLAIN;
            desc.vrank = 7'(my_rank_reg - rem);
        end
    end

    assign q_wr.push = s_tvalid && s_tready;
    assign q_wr.data = desc;

endmodule

`default_nettype wire

/* rtl/core/rshs_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on rshs_pkg and the assertion macro header.
`default_nettype none

`include "reduce_scatter_halving_scheduler_macros.svh"

module rshs_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  rshs_pkg::q_wr_t  q_wr,
    output logic             q_full,
    input  wire logic        q_pop,
    output rshs_pkg::q_rd_t  q_rd
);

    localparam logic [1:0] FULL_COUNT = 2'(rshs_pkg::QUEUE_DEPTH);

    rshs_pkg::desc_t entry_reg [rshs_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_full     = (count_reg == FULL_COUNT);
    assign q_rd.valid = (count_reg != 2'd0);
    assign q_rd.data  = entry_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb begin
        wr_ptr_next = q_wr.push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!q_wr.push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            entry_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

    `RSHS_ASSERT_SAME(a_no_push_full, aclk, aresetn, q_wr.push, count_reg != FULL_COUNT, "push into full queue")
    `RSHS_ASSERT_SAME(a_no_pop_empty, aclk, aresetn, q_pop, count_reg != 2'd0, "pop from empty queue")
    `RSHS_ASSERT_NEXT(a_fill_up, aclk, aresetn, q_wr.push && !q_pop, count_reg == 2'($past(count_reg) + 2'd1), "fill count did not rise")

endmodule

`default_nettype wire

/* rtl/core/rshs_back.sv */
// Back end: schedule sequencer walking fold-in, halving rounds, copy-out and
// fold-out, with a registered result stage. Depends on rshs_pkg and the macros.
`default_nettype none

`include "reduce_scatter_halving_scheduler_macros.svh"

module rshs_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  rshs_pkg::q_rd_t  q_rd,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rshs_pkg::item_t  out_item
);

    rshs_pkg::phase_t state_reg, state_next;
    rshs_pkg::desc_t  desc_reg;
    logic [6:0] mask_reg, mask_next;
    logic [6:0] sidx_reg, sidx_next;
    logic [6:0] ridx_reg, ridx_next;
    logic [6:0] lidx_reg, lidx_next;
    logic       out_valid_reg, out_valid_next;
    rshs_pkg::item_t item_reg, item_next;

    logic        advance;
    logic        out_load;
    logic [6:0]  vpeer;
    logic        lower;
    logic [6:0]  s_new, r_new;
    logic [26:0] vd_s, vd_r, vd_l;
    logic [6:0]  dst;
    logic [26:0] sc, rc;
    logic        rounds_follow;

    assign advance  = !out_valid_reg || out_ready;
    assign out_load = advance && (state_reg != rshs_pkg::PH_IDLE);
    assign q_pop    = (state_reg == rshs_pkg::PH_IDLE) && q_rd.valid;

    // Halving round arithmetic
    always_comb begin
        vpeer = desc_reg.vrank ^ mask_reg;
        lower = desc_reg.vrank < vpeer;
        s_new = lower ? 7'(ridx_reg + mask_reg) : sidx_reg;
        r_new = lower ? ridx_reg : 7'(sidx_reg + mask_reg);
        vd_s  = rshs_pkg::vdisp(s_new, desc_reg.rem, desc_reg.blk);
        vd_r  = rshs_pkg::vdisp(r_new, desc_reg.rem, desc_reg.blk);
        vd_l  = rshs_pkg::vdisp(lidx_reg, desc_reg.rem, desc_reg.blk);
        sc    = lower ? 27'(vd_l - vd_s) : 27'(vd_r - vd_s);
        rc    = lower ? 27'(vd_s - vd_r) : 27'(vd_l - vd_r);
        dst   = (vpeer < {1'b0, desc_reg.rem}) ? 7'({vpeer[5:0], 1'b1})
                                               : 7'(vpeer + {1'b0, desc_reg.rem});
    end

    assign rounds_follow = (mask_reg != 7'd0);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rshs_pkg::PH_IDLE: begin
                if (q_rd.valid) begin
                    state_next = q_rd.data.empty ? rshs_pkg::PH_EMPTY : rshs_pkg::PH_LOAD;
                end
            end
            rshs_pkg::PH_EMPTY: begin
                if (advance) state_next = rshs_pkg::PH_IDLE;
            end
            rshs_pkg::PH_LOAD: begin
                if (advance) begin
                    if (desc_reg.role != rshs_pkg::ROLE_PLAIN) begin
                        state_next = rshs_pkg::PH_FOLD_IN;
                    end else begin
                        state_next = rounds_follow ? rshs_pkg::PH_ROUND : rshs_pkg::PH_COPY;
                    end
                end
            end
            rshs_pkg::PH_FOLD_IN: begin
                if (advance) begin
                    if (desc_reg.role == rshs_pkg::ROLE_FOLD_SEND) begin
                        state_next = rshs_pkg::PH_FOLD_OUT;
                    end else begin
                        state_next = rounds_follow ? rshs_pkg::PH_ROUND : rshs_pkg::PH_COPY;
                    end
                end
            end
            rshs_pkg::PH_ROUND: begin
                if (advance) begin
                    state_next = (mask_reg[6:1] != 6'd0) ? rshs_pkg::PH_ROUND
                                                         : rshs_pkg::PH_COPY;
                end
            end
            rshs_pkg::PH_COPY: begin
                if (advance) begin
                    state_next = (desc_reg.role == rshs_pkg::ROLE_FOLD_RECV) ?
                                 rshs_pkg::PH_FOLD_OUT : rshs_pkg::PH_IDLE;
                end
            end
            rshs_pkg::PH_FOLD_OUT: begin
                if (advance) state_next = rshs_pkg::PH_IDLE;
            end
            default: state_next = rshs_pkg::PH_IDLE;
        endcase
    end

    // Item contents for the current phase
    always_comb begin
        item_next = '0;
        item_next.kind = rshs_pkg::KIND_EMPTY;
        unique case (state_reg)
            rshs_pkg::PH_EMPTY: begin
                item_next.last = 1'b1;
            end
            rshs_pkg::PH_LOAD: begin
                item_next.kind = desc_reg.in_place ? rshs_pkg::KIND_LOAD_RECV
                                                   : rshs_pkg::KIND_LOAD_SEND;
                item_next.send_count = desc_reg.total;
            end
            rshs_pkg::PH_FOLD_IN: begin
                if (desc_reg.role == rshs_pkg::ROLE_FOLD_SEND) begin
                    item_next.kind        = rshs_pkg::KIND_SEND_ALL;
                    item_next.peer        = 6'(desc_reg.rank + 6'd1);
                    item_next.send_count  = desc_reg.total;
                    item_next.send_active = 1'b1;
                end else begin
                    item_next.kind        = rshs_pkg::KIND_RECV_ALL;
                    item_next.peer        = 6'(desc_reg.rank - 6'd1);
                    item_next.recv_count  = desc_reg.total;
                    item_next.recv_active = 1'b1;
                end
            end
            rshs_pkg::PH_ROUND: begin
                item_next.kind        = rshs_pkg::KIND_ROUND;
                item_next.peer        = dst[5:0];
                item_next.send_offset = vd_s[25:0];
                item_next.send_count  = sc;
                item_next.recv_offset = vd_r[25:0];
                item_next.recv_count  = rc;
                item_next.send_active = (sc != 27'd0);
                item_next.recv_active = (rc != 27'd0);
            end
            rshs_pkg::PH_COPY: begin
                item_next.kind        = rshs_pkg::KIND_COPY_OUT;
                item_next.send_offset = desc_reg.rank_blk;
                item_next.send_count  = 27'(desc_reg.blk);
                item_next.last        = (desc_reg.role != rshs_pkg::ROLE_FOLD_RECV);
            end
            rshs_pkg::PH_FOLD_OUT: begin
                item_next.last = 1'b1;
                if (desc_reg.role == rshs_pkg::ROLE_FOLD_RECV) begin
                    item_next.kind        = rshs_pkg::KIND_SEND_RES;
                    item_next.peer        = 6'(desc_reg.rank - 6'd1);
                    item_next.send_offset = 26'(desc_reg.rank_blk - 26'(desc_reg.blk));
                    item_next.send_count  = 27'(desc_reg.blk);
                    item_next.send_active = 1'b1;
                end else begin
                    item_next.kind        = rshs_pkg::KIND_RECV_RES;
                    item_next.peer        = 6'(desc_reg.rank + 6'd1);
                    item_next.recv_count  = 27'(desc_reg.blk);
                    item_next.recv_active = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Round walk registers
    always_comb begin
        mask_next = mask_reg;
        sidx_next = sidx_reg;
        ridx_next = ridx_reg;
        lidx_next = lidx_reg;
        if (q_pop) begin
            mask_next = {1'b0, q_rd.data.pof2[6:1]};
            sidx_next = 7'd0;
            ridx_next = 7'd0;
            lidx_next = q_rd.data.pof2;
        end else if (out_load && (state_reg == rshs_pkg::PH_ROUND)) begin
            mask_next = {1'b0, mask_reg[6:1]};
            sidx_next = r_new;
            ridx_next = r_new;
            lidx_next = 7'(r_new + mask_reg);
        end
    end

    // Output register hand-off
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rshs_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
            mask_reg      <= 7'd0;
            sidx_reg      <= 7'd0;
            ridx_reg      <= 7'd0;
            lidx_reg      <= 7'd0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            sidx_reg      <= sidx_next;
            ridx_reg      <= ridx_next;
            lidx_reg      <= lidx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            desc_reg <= q_rd.data;
        end
        if (out_load) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

    `RSHS_ASSERT_SAME(a_round_mask, aclk, aresetn, state_reg == rshs_pkg::PH_ROUND, mask_reg != 7'd0, "halving round with zero mask")
    `RSHS_ASSERT_SAME(a_copy_role, aclk, aresetn, state_reg == rshs_pkg::PH_COPY, desc_reg.role != rshs_pkg::ROLE_FOLD_SEND, "folded-out rank reached copy-out")
    `RSHS_ASSERT_NEXT(a_last_idle, aclk, aresetn, out_load && item_next.last, state_reg == rshs_pkg::PH_IDLE, "schedule continued after last item")

endmodule

`default_nettype wire

/* rtl/core/reduce_scatter_halving_scheduler.sv */
// Recursive-halving reduce-scatter schedule generator, top level.
// Depends on rshs_pkg, rshs_front, rshs_queue and rshs_back.
//
// Usage:
//   Write group_size (index 0) and my_rank (index 1) on the cfg channel while
//   the block is idle. Each start transaction on the s_ channel carries the
//   per-rank block count in s_tdata and the in-place flag in s_tuser. The
//   block answers on the m_ channel with a run of 1 to 9 schedule items, the
//   kind in m_tuser and m_tlast on the final item of the run.
// Item flow:
//   The first item of a run passes the queue, the sequencer state and the
//   output register before it is valid. The sequencer then gives one item
//   per cycle while m_tready is high, passing through idle to take the next
//   command from the queue; the single sequencer is what bounds the rate.
//   Two further start commands wait in the queue while a run is in progress.
// Reset:
//   aresetn (synchronous, active low) sets group_size to 1, my_rank to 0 and
//   empties the queue and the output register.
// Stall:
//   While m_tready is low the current item holds and the sequencer waits;
//   once the queue is full s_tready drops.
`default_nettype none

module reduce_scatter_halving_scheduler (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // configuration
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [0:0]     cfg_index,
    input  wire logic [6:0]     cfg_data,
    // start commands
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [23:0]    s_tdata,   // [19:0] block_count, [23:20] zero
    input  wire logic [0:0]     s_tuser,   // [0] in_place
    // schedule items
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [119:0]        m_tdata,   // [5:0] peer, [31:6] send_offset,
                                           // [58:32] send_count, [84:59] recv_offset,
                                           // [111:85] recv_count, [112] send_active,
                                           // [113] recv_active, [119:114] zero
    output logic [3:0]          m_tuser,   // [3:0] kind
    output logic                m_tlast
);

    rshs_pkg::q_wr_t  q_wr;
    rshs_pkg::q_rd_t  q_rd;
    rshs_pkg::item_t  item;
    logic             q_full;
    logic             q_pop;

    rshs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .blk_in      (s_tdata[19:0]),
        .in_place_in (s_tuser[0]),
        .q_full      (q_full),
        .q_wr        (q_wr)
    );

    rshs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rd    (q_rd)
    );

    rshs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    // Item packing
    assign m_tdata = {6'd0, item.recv_active, item.send_active, item.recv_count,
                      item.recv_offset, item.send_count, item.send_offset, item.peer};
    assign m_tuser = item.kind;
    assign m_tlast = item.last;

endmodule

`default_nettype wire

/* sim/reduce_scatter_halving_scheduler_tb.sv */
// Self-checking testbench for the recursive-halving reduce-scatter schedule generator.
// Depends on rshs_pkg and reduce_scatter_halving_scheduler; needs nothing else.
`timescale 1ns / 1ps

module reduce_scatter_halving_scheduler_tb;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = '0;
    logic [6:0]   cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata   = '0;   // [19:0] block_count, [23:20] zero
    logic [0:0]   s_tuser   = '0;   // [0] in_place
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [119:0] m_tdata;          // peer, send_offset, send_count, recv_offset,
                                    // recv_count, send_active, recv_active
    logic [3:0]   m_tuser;          // [3:0] kind
    logic         m_tlast;

    int send_idle_pct = 36;
    int recv_idle_pct = 53;
    int settings_seen = 0;
    logic [6:0] cur_group = 7'd1;
    logic [6:0] cur_rank  = 7'd0;

    // Schedule predictor and store of expected schedule items
    class schedule_scoreboard;
        logic [6:0]      group_size;
        logic [5:0]      my_rank;
        rshs_pkg::item_t sched_q[$];
        int              errors;
        int              checked;
        int              starts;

        function new();
            group_size = 7'd1;
            my_rank    = 6'd0;
            errors     = 0;
            checked    = 0;
            starts     = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [6:0] val);
            if (idx == rshs_pkg::REG_GROUP_SIZE)
                group_size = val;
            else
                my_rank = val[5:0];
        endfunction

        function int pending();
            return sched_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // element offset of virtual block idx; blocks below rem are double size
        function longint unsigned block_offset(longint unsigned idx, longint unsigned rem,
                                               longint unsigned blk);
            return blk * (idx + ((idx < rem) ? idx : rem));
        endfunction

        function void add_item(rshs_pkg::kind_t kind, longint unsigned peer,
                               longint unsigned so, longint unsigned sc,
                               longint unsigned ro, longint unsigned rc, bit sa, bit ra);
            rshs_pkg::item_t e;
            e.kind        = kind;
            e.peer        = peer[5:0];
            e.send_offset = so[25:0];
            e.send_count  = sc[26:0];
            e.recv_offset = ro[25:0];
            e.recv_count  = rc[26:0];
            e.send_active = sa;
            e.recv_active = ra;
            e.last        = 1'b0;
            sched_q.push_back(e);
        endfunction

        // Work out the whole schedule for one start transaction
        function void note_start(logic [19:0] blk_in, logic inpl);
            longint unsigned blk, size, rank, total, pof2, rem, vrank, vpeer, dst;
            longint unsigned mask, sidx, ridx, lim, sc, rc;
            bit joins;
            rshs_pkg::item_t tail;
            blk   = blk_in;
            size  = (group_size > rshs_pkg::MAX_RANKS) ? rshs_pkg::MAX_RANKS : group_size;
            rank  = my_rank;
            joins = 1'b1;
            vrank = 0;
            starts++;
            if (blk == 0 || rank >= size) begin
                add_item(rshs_pkg::KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0);
            end else begin
                total = size * blk;
                add_item(inpl ? rshs_pkg::KIND_LOAD_RECV : rshs_pkg::KIND_LOAD_SEND,
                         0, 0, total, 0, 0, 0, 0);
                pof2 = 1;
                while (pof2 * 2 <= size)
                    pof2 *= 2;
                rem = size - pof2;
                // fold-in of the ranks beyond the power of two
                if (rank < 2 * rem) begin
                    if (rank[0] == 1'b0) begin
                        add_item(rshs_pkg::KIND_SEND_ALL, rank + 1, 0, total, 0, 0, 1, 0);
                        joins = 1'b0;
                    end else begin
                        add_item(rshs_pkg::KIND_RECV_ALL, rank - 1, 0, 0, 0, total, 0, 1);
                        vrank = rank >> 1;
                    end
                end else begin
                    vrank = rank - rem;
                end
                // halving rounds
                if (joins) begin
                    mask = pof2 >> 1;
                    sidx = 0;
                    ridx = 0;
                    lim  = pof2;
                    while (mask != 0) begin
                        vpeer = vrank ^ mask;
                        dst   = (vpeer < rem) ? vpeer * 2 + 1 : vpeer + rem;
                        if (vrank < vpeer) begin
                            sidx = ridx + mask;
                            sc = block_offset(lim, rem, blk) - block_offset(sidx, rem, blk);
                            rc = block_offset(sidx, rem, blk) - block_offset(ridx, rem, blk);
                        end else begin
                            ridx = sidx + mask;
                            sc = block_offset(ridx, rem, blk) - block_offset(sidx, rem, blk);
                            rc = block_offset(lim, rem, blk) - block_offset(ridx, rem, blk);
                        end
                        add_item(rshs_pkg::KIND_ROUND, dst, block_offset(sidx, rem, blk), sc,
                                 block_offset(ridx, rem, blk), rc, sc != 0, rc != 0);
                        sidx = ridx;
                        lim  = ridx + mask;
                        mask = mask >> 1;
                    end
                    add_item(rshs_pkg::KIND_COPY_OUT, 0, rank * blk, blk, 0, 0, 0, 0);
                end
                // fold-out of the result
                if (rank < 2 * rem) begin
                    if (rank[0])
                        add_item(rshs_pkg::KIND_SEND_RES, rank - 1, (rank - 1) * blk, blk,
                                 0, 0, 1, 0);
                    else
                        add_item(rshs_pkg::KIND_RECV_RES, rank + 1, 0, 0, 0, blk, 0, 1);
                end
            end
            tail = sched_q.pop_back();
            tail.last = 1'b1;
            sched_q.push_back(tail);
        endfunction

        task check_item(rshs_pkg::item_t got);
            rshs_pkg::item_t e;
            checked++;
            if (sched_q.size() == 0) begin
                report_mismatch($sformatf("item %0d arrived with nothing expected", checked));
                return;
            end
            e = sched_q.pop_front();
            if (got.kind !== e.kind)
                report_mismatch($sformatf("item %0d kind %0d, expected %0d",
                                          checked, got.kind, e.kind));
            if (got.peer !== e.peer)
                report_mismatch($sformatf("item %0d peer %0d, expected %0d",
                                          checked, got.peer, e.peer));
            if (got.send_offset !== e.send_offset)
                report_mismatch($sformatf("item %0d send_offset %0d, expected %0d",
                                          checked, got.send_offset, e.send_offset));
            if (got.send_count !== e.send_count)
                report_mismatch($sformatf("item %0d send_count %0d, expected %0d",
                                          checked, got.send_count, e.send_count));
            if (got.recv_offset !== e.recv_offset)
                report_mismatch($sformatf("item %0d recv_offset %0d, expected %0d",
                                          checked, got.recv_offset, e.recv_offset));
            if (got.recv_count !== e.recv_count)
                report_mismatch($sformatf("item %0d recv_count %0d, expected %0d",
                                          checked, got.recv_count, e.recv_count));
            if (got.send_active !== e.send_active)
                report_mismatch($sformatf("item %0d send_active %0b, expected %0b",
                                          checked, got.send_active, e.send_active));
            if (got.recv_active !== e.recv_active)
                report_mismatch($sformatf("item %0d recv_active %0b, expected %0b",
                                          checked, got.recv_active, e.recv_active));
            if (got.last !== e.last)
                report_mismatch($sformatf("item %0d tlast %0b, expected %0b",
                                          checked, got.last, e.last));
        endtask
    endclass

    schedule_scoreboard sb = new();

    reduce_scatter_halving_scheduler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor: every accepted transaction goes to the scoreboard
    always @(posedge aclk) begin : result_monitor
        rshs_pkg::item_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind        = rshs_pkg::kind_t'(m_tuser);
            got.peer        = m_tdata[5:0];
            got.send_offset = m_tdata[31:6];
            got.send_count  = m_tdata[58:32];
            got.recv_offset = m_tdata[84:59];
            got.recv_count  = m_tdata[111:85];
            got.send_active = m_tdata[112];
            got.recv_active = m_tdata[113];
            got.last        = m_tlast;
            sb.check_item(got);
        end
    end

    // Watchdog
    initial begin
        #5ms;
        $display("reduce_scatter_halving_scheduler test failed");
        $finish;
    end

    task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_start(input logic [19:0] blk, input logic inpl);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, blk};
        s_tuser  <= inpl;
        do @(posedge aclk); while (!s_tready);
        sb.note_start(blk, inpl);
    endtask

    // Stop sending and let every outstanding schedule item come out
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [6:0] gs, input logic [6:0] rk);
        wait_drain();
        write_reg(rshs_pkg::REG_GROUP_SIZE, gs);
        write_reg(rshs_pkg::REG_MY_RANK, rk);
        cur_group = gs;
        cur_rank  = rk;
        settings_seen++;
    endtask

    // Directed case: rewrite the registers only when the setting changes
    task automatic run_case(input logic [6:0] gs, input logic [6:0] rk,
                            input logic [19:0] blk, input logic inpl);
        if (gs != cur_group || rk != cur_rank)
            apply_setting(gs, rk);
        send_start(blk, inpl);
    endtask

    task automatic random_setting();
        logic [6:0] gs;
        logic [6:0] rk;
        int eff;
        case ($urandom_range(9))
            0:       gs = 7'd64;
            1:       gs = 7'd1;
            2:       gs = 7'($urandom_range(127, 65));
            3:       gs = 7'd0;
            default: gs = 7'($urandom_range(63, 2));
        endcase
        eff = (gs > rshs_pkg::MAX_RANKS) ? rshs_pkg::MAX_RANKS : gs;
        if (eff == 0 || $urandom_range(7) == 0)
            rk = 7'($urandom_range(127, 0));
        else
            rk = 7'($urandom_range(eff - 1, 0));
        apply_setting(gs, rk);
    endtask

    function automatic logic [19:0] pick_count();
        case ($urandom_range(9))
            0:       return 20'd0;
            1:       return 20'hFFFFF;
            2, 3, 4: return 20'($urandom_range(16, 1));
            default: return 20'($urandom());
        endcase
    endfunction

    // Stimulus
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset setting, extremes, saturation, outside ranks, fold roles
        run_case(7'd1,  7'd0,  20'd0,      1'b0);
        run_case(7'd1,  7'd0,  20'd1,      1'b0);
        run_case(7'd1,  7'd0,  20'hFFFFF,  1'b1);
        run_case(7'd64, 7'd63, 20'hFFFFF,  1'b0);
        run_case(7'd64, 7'd63, 20'd1,      1'b1);
        run_case(7'd64, 7'd0,  20'd0,      1'b1);
        run_case(7'd64, 7'd0,  20'd12345,  1'b0);
        run_case(7'd127, 7'd5, 20'd1000,   1'b0);
        run_case(7'd0,  7'd0,  20'd5,      1'b0);
        run_case(7'd5,  7'd7,  20'd3,      1'b1);
        run_case(7'd6,  7'd0,  20'd7,      1'b1);
        run_case(7'd6,  7'd0,  20'hFFFFF,  1'b0);
        run_case(7'd6,  7'd3,  20'hFFFFF,  1'b0);
        run_case(7'd6,  7'd5,  20'd9,      1'b1);
        run_case(7'd48, 7'd31, 20'hFFFFF,  1'b0);
        run_case(7'd48, 7'd30, 20'd77,     1'b1);
        run_case(7'd3,  7'd2,  20'd2,      1'b0);
        run_case(7'd3,  7'h41, 20'd4,      1'b1);
        run_case(7'd63, 7'd62, 20'h80000,  1'b0);
        run_case(7'd2,  7'd1,  20'd1,      1'b1);

        // random part in three idling regimes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 53 : 0;
            recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 36 : 0;
            for (int n = 0; n < 120; n++) begin
                if (n % 15 == 0)
                    random_setting();
                else if (n % 15 == 7)
                    wait_drain();
                send_start(pick_count(), 1'($urandom_range(1, 0)));
            end
        end

        wait_drain();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d schedule items never arrived", sb.pending()));
        $display("Run covered %0d start commands, %0d schedule items checked, %0d settings",
                 sb.starts, sb.checked, settings_seen);
        $display("Mismatches reported: %0d", sb.errors);
        if (sb.errors == 0)
            $display("reduce_scatter_halving_scheduler test passed");
        else
            $display("reduce_scatter_halving_scheduler test failed");
        $finish;
    end

endmodule
